[design/clw_pkg.sv]
// Shared types and constants of the circle lead waypoint unit.
// CORDIC arctangent table, gain constant, angle limits and register indexes.
// No dependencies.
package clw_pkg;

	localparam int GUARD_BITS = 8;
	localparam int TABLE_SIZE = 24;
	localparam int ZR_W = 34;

	// atan(2^-i) in 32-bit binary angle units
	localparam logic [31:0] ATAN_TURNS [TABLE_SIZE] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;
	localparam logic signed [ZR_W-1:0] ZR_QUARTER = 34'sd1073741824;
	localparam logic signed [ZR_W-1:0] ZR_HALF = 34'sd2147483648;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_ANGLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLOCKWISE = 3'd5;

	// flags that ride along with each request through the cell rows
	typedef struct packed {
		logic calc;
		logic zero;
		logic last;
	} side_t;

endpackage

[design/clw_in_if.sv]
// Agent position channel of the circle lead waypoint unit.
// Valid/ready handshake with the agent fields; no dependencies.
interface clw_in_if #(
	parameter int POSITION_WIDTH = 24
);
	logic valid;
	logic ready;
	logic signed [POSITION_WIDTH-1:0] pos_x;
	logic signed [POSITION_WIDTH-1:0] pos_y;
	logic is_tracked;
	logic has_control;
	logic last_agent;

	modport source (output valid, pos_x, pos_y, is_tracked, has_control, last_agent,
		input ready);
	modport sink (input valid, pos_x, pos_y, is_tracked, has_control, last_agent,
		output ready);
endinterface

[design/clw_out_if.sv]
// Waypoint channel of the circle lead waypoint unit.
// Valid/ready handshake with the waypoint fields; no dependencies.
interface clw_out_if #(
	parameter int POSITION_WIDTH = 24
);
	logic valid;
	logic ready;
	logic waypoint_valid;
	logic signed [POSITION_WIDTH-1:0] waypoint_x;
	logic signed [POSITION_WIDTH-1:0] waypoint_y;
	logic signed [POSITION_WIDTH-1:0] waypoint_z;
	logic end_of_message;

	modport source (output valid, waypoint_valid, waypoint_x, waypoint_y, waypoint_z,
		end_of_message, input ready);
	modport sink (input valid, waypoint_valid, waypoint_x, waypoint_y, waypoint_z,
		end_of_message, output ready);
endinterface

[design/circle_lead_waypoint_unit.sv]
// Top level of the circle lead waypoint unit: config registers, prep, angle and
// output stages around a row of vectoring cells and a row of rotation cells.
// Depends on clw_pkg, clw_in_if, clw_out_if, clw_vec_cell and clw_rot_cell.
//
// Takes one agent request per clock cycle while the output is not stalled and
// returns exactly one waypoint request per agent, in order. A request passes
// through the prep stage, the row of vectoring cells (one micro-rotation per
// cell), the angle stage, the row of rotation cells and the output stage.
// Every stage has its own valid bit, so empty stages fill while the output
// waits. Configuration registers are read directly by the stages and must be
// written only while no request is in flight.
module circle_lead_waypoint_unit
	import clw_pkg::*;
#(
	parameter int POSITION_WIDTH = 24,
	parameter int ANGLE_WIDTH = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [((POSITION_WIDTH > 16) ? POSITION_WIDTH : 16)-1:0] cfg_data,
	clw_in_if.sink agent,
	clw_out_if.source waypoint
);
	localparam int P = POSITION_WIDTH;
	localparam int A = ANGLE_WIDTH;
	localparam int N = CORDIC_STAGES;
	localparam int DW = P + 1;
	localparam int VW = P + 12;
	localparam int RW = P + 10;
	localparam int MW = P + 30;
	localparam int X0W = P + 7;
	localparam int FW = RW - GUARD_BITS;
	localparam int SW = P + 3;
	localparam logic signed [SW-1:0] SAT_HI = {{(SW-P+1){1'b0}}, {(P-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = {{(SW-P+1){1'b1}}, {(P-1){1'b0}}};

	// configuration registers
	logic signed [P-1:0] ctr_x_q, ctr_y_q, height_q;
	logic [P-2:0] radius_q;
	logic [15:0] lead_q;
	logic clockwise_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_x_q <= '0;
			ctr_y_q <= '0;
			radius_q <= (P-1)'(65536);
			lead_q <= 16'd8344;
			height_q <= P'(65536);
			clockwise_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CENTER_X: ctr_x_q <= cfg_data[P-1:0];
				REG_CENTER_Y: ctr_y_q <= cfg_data[P-1:0];
				REG_RADIUS: radius_q <= cfg_data[P-2:0];
				REG_LEAD_ANGLE: lead_q <= cfg_data[15:0];
				REG_TARGET_HEIGHT: height_q <= cfg_data[P-1:0];
				REG_CLOCKWISE: clockwise_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// row wiring: index k is the input of cell k, index N the row output
	logic vv [0:N];
	logic vrdy [0:N];
	logic signed [VW-1:0] vx [0:N];
	logic signed [VW-1:0] vy [0:N];
	logic [31:0] vz [0:N];
	side_t vside [0:N];

	logic rv [0:N];
	logic rrdy [0:N];
	logic signed [RW-1:0] rx [0:N];
	logic signed [RW-1:0] ry [0:N];
	logic signed [ZR_W-1:0] rz [0:N];
	side_t rside [0:N];

	// prep stage: offset from center, guard bits, fold into the right half plane
	logic v_s1;
	logic signed [VW-1:0] x_s1, y_s1;
	logic [31:0] z_s1;
	side_t side_s1;
	logic signed [DW-1:0] dx, dy;
	logic signed [VW-1:0] gx, gy;

	assign dx = DW'(agent.pos_x) - DW'(ctr_x_q);
	assign dy = DW'(agent.pos_y) - DW'(ctr_y_q);
	assign gx = VW'(dx) <<< GUARD_BITS;
	assign gy = VW'(dy) <<< GUARD_BITS;
	assign agent.ready = !v_s1 || vrdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (agent.ready) begin
			v_s1 <= agent.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (agent.ready && agent.valid) begin
			if (gx[VW-1] && !gy[VW-1]) begin
				x_s1 <= gy;
				y_s1 <= -gx;
				z_s1 <= QUARTER_TURN;
			end else if (gx[VW-1]) begin
				x_s1 <= -gy;
				y_s1 <= gx;
				z_s1 <= THREE_QUARTER_TURN;
			end else begin
				x_s1 <= gx;
				y_s1 <= gy;
				z_s1 <= '0;
			end
			side_s1.calc <= agent.is_tracked && !agent.has_control;
			side_s1.zero <= (dx == '0) && (dy == '0);
			side_s1.last <= agent.last_agent;
		end
	end

	assign vv[0] = v_s1;
	assign vx[0] = x_s1;
	assign vy[0] = y_s1;
	assign vz[0] = z_s1;
	assign vside[0] = side_s1;

	for (genvar k = 0; k < N; k++) begin : g_vec
		clw_vec_cell #(.W(VW), .STAGE(k)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(vv[k]), .in_ready(vrdy[k]),
			.in_x(vx[k]), .in_y(vy[k]), .in_z(vz[k]), .in_side(vside[k]),
			.out_valid(vv[k+1]), .out_ready(vrdy[k+1]),
			.out_x(vx[k+1]), .out_y(vy[k+1]), .out_z(vz[k+1]), .out_side(vside[k+1])
		);
	end

	// angle stage: round bearing, apply lead, fold to +-quarter turn, scale radius
	logic v_s2;
	logic signed [ZR_W-1:0] zs_s2;
	logic neg_s2;
	logic [X0W-1:0] x0_s2;
	side_t side_s2;
	logic [32:0] zsum;
	logic [A-1:0] bear, lead_a, target;
	logic [A+15:0] lead_w;
	logic [31:0] a32;
	logic signed [ZR_W-1:0] zs;
	logic [MW-1:0] prod, prod_rnd;

	assign zsum = {1'b0, vz[N]} + (33'd1 << (31 - A));
	assign bear = vside[N].zero ? '0 : zsum[31 -: A];
	assign lead_w = (A+16)'(lead_q) << A;
	assign lead_a = lead_w[A+15 -: A];
	assign target = clockwise_q ? (bear - lead_a) : (bear + lead_a);
	assign a32 = {target, {(32-A){1'b0}}};
	assign zs = ZR_W'($signed(a32));
	assign prod = MW'(radius_q) * MW'(INV_GAIN_Q30);
	assign prod_rnd = prod + (MW'(1) << (29 - GUARD_BITS));
	assign vrdy[N] = !v_s2 || rrdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (vrdy[N]) begin
			v_s2 <= vv[N];
		end
	end

	always_ff @(posedge clk) begin
		if (vrdy[N] && vv[N]) begin
			if (zs > ZR_QUARTER) begin
				zs_s2 <= zs - ZR_HALF;
				neg_s2 <= 1'b1;
			end else if (zs < -ZR_QUARTER) begin
				zs_s2 <= zs + ZR_HALF;
				neg_s2 <= 1'b1;
			end else begin
				zs_s2 <= zs;
				neg_s2 <= 1'b0;
			end
			x0_s2 <= prod_rnd[X0W+29-GUARD_BITS : 30-GUARD_BITS];
			side_s2 <= vside[N];
		end
	end

	logic signed [RW-1:0] x0_ext;
	assign x0_ext = RW'(x0_s2);

	assign rv[0] = v_s2;
	assign rx[0] = neg_s2 ? -x0_ext : x0_ext;
	assign ry[0] = '0;
	assign rz[0] = zs_s2;
	assign rside[0] = side_s2;

	for (genvar k = 0; k < N; k++) begin : g_rot
		clw_rot_cell #(.W(RW), .STAGE(k)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(rv[k]), .in_ready(rrdy[k]),
			.in_x(rx[k]), .in_y(ry[k]), .in_z(rz[k]), .in_side(rside[k]),
			.out_valid(rv[k+1]), .out_ready(rrdy[k+1]),
			.out_x(rx[k+1]), .out_y(ry[k+1]), .out_z(rz[k+1]), .out_side(rside[k+1])
		);
	end

	// output stage: drop guard bits with rounding, add center, saturate
	logic v_s3;
	logic valid_s3, last_s3;
	logic signed [P-1:0] wx_s3, wy_s3, wz_s3;
	logic signed [RW-1:0] xr_full, yr_full;
	logic signed [FW-1:0] xr, yr;
	logic signed [SW-1:0] sx, sy;
	logic signed [P-1:0] satx, saty;

	assign xr_full = rx[N] + RW'(1 << (GUARD_BITS - 1));
	assign yr_full = ry[N] + RW'(1 << (GUARD_BITS - 1));
	assign xr = xr_full[RW-1:GUARD_BITS];
	assign yr = yr_full[RW-1:GUARD_BITS];
	assign sx = SW'(xr) + SW'(ctr_x_q);
	assign sy = SW'(yr) + SW'(ctr_y_q);

	always_comb begin
		if (sx > SAT_HI) begin
			satx = SAT_HI[P-1:0];
		end else if (sx < SAT_LO) begin
			satx = SAT_LO[P-1:0];
		end else begin
			satx = sx[P-1:0];
		end
		if (sy > SAT_HI) begin
			saty = SAT_HI[P-1:0];
		end else if (sy < SAT_LO) begin
			saty = SAT_LO[P-1:0];
		end else begin
			saty = sy[P-1:0];
		end
	end

	assign rrdy[N] = !v_s3 || waypoint.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rrdy[N]) begin
			v_s3 <= rv[N];
		end
	end

	always_ff @(posedge clk) begin
		if (rrdy[N] && rv[N]) begin
			valid_s3 <= rside[N].calc;
			wx_s3 <= rside[N].calc ? satx : '0;
			wy_s3 <= rside[N].calc ? saty : '0;
			wz_s3 <= rside[N].calc ? height_q : '0;
			last_s3 <= rside[N].last;
		end
	end

	assign waypoint.valid = v_s3;
	assign waypoint.waypoint_valid = valid_s3;
	assign waypoint.waypoint_x = wx_s3;
	assign waypoint.waypoint_y = wy_s3;
	assign waypoint.waypoint_z = wz_s3;
	assign waypoint.end_of_message = last_s3;

	a_idle_prep_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> agent.ready)
		else $error("prep stage empty but agent request refused");

	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && side_s1.zero |-> (x_s1 == '0) && (y_s1 == '0))
		else $error("zero offset flagged with nonzero vector");

	a_angle_folded: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (zs_s2 <= ZR_QUARTER) && (zs_s2 >= -ZR_QUARTER))
		else $error("rotation angle outside quarter turn after fold");

	a_pass_through_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !valid_s3 |-> (wx_s3 == '0) && (wy_s3 == '0) && (wz_s3 == '0))
		else $error("pass-through agent carries nonzero waypoint");
endmodule

[design/clw_vec_cell.sv]
// One CORDIC vectoring micro-rotation with its own handshake register.
// Depends on clw_pkg for the arctangent table and side flags.
module clw_vec_cell
	import clw_pkg::*;
#(
	parameter int W = 36,
	parameter int STAGE = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [W-1:0] in_x,
	input  logic signed [W-1:0] in_y,
	input  logic [31:0]         in_z,
	input  side_t               in_side,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [W-1:0] out_x,
	output logic signed [W-1:0] out_y,
	output logic [31:0]         out_z,
	output side_t               out_side
);
	logic valid_q;
	logic signed [W-1:0] x_q, y_q;
	logic [31:0] z_q;
	side_t side_q;
	logic signed [W-1:0] xs, ys;

	assign xs = in_x >>> STAGE;
	assign ys = in_y >>> STAGE;
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// drive y toward zero, accumulate the angle
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			if (!in_y[W-1]) begin
				x_q <= in_x + ys;
				y_q <= in_y - xs;
				z_q <= in_z + ATAN_TURNS[STAGE];
			end else begin
				x_q <= in_x - ys;
				y_q <= in_y + xs;
				z_q <= in_z - ATAN_TURNS[STAGE];
			end
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_x = x_q;
	assign out_y = y_q;
	assign out_z = z_q;
	assign out_side = side_q;
endmodule

[design/clw_rot_cell.sv]
// One CORDIC rotation micro-rotation with its own handshake register.
// Depends on clw_pkg for the arctangent table and side flags.
module clw_rot_cell
	import clw_pkg::*;
#(
	parameter int W = 34,
	parameter int STAGE = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [W-1:0]    in_x,
	input  logic signed [W-1:0]    in_y,
	input  logic signed [ZR_W-1:0] in_z,
	input  side_t                  in_side,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [W-1:0]    out_x,
	output logic signed [W-1:0]    out_y,
	output logic signed [ZR_W-1:0] out_z,
	output side_t                  out_side
);
	logic valid_q;
	logic signed [W-1:0] x_q, y_q;
	logic signed [ZR_W-1:0] z_q;
	side_t side_q;
	logic signed [W-1:0] xs, ys;
	logic signed [ZR_W-1:0] step;

	assign xs = in_x >>> STAGE;
	assign ys = in_y >>> STAGE;
	assign step = $signed({2'b00, ATAN_TURNS[STAGE]});
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// drive the residual angle toward zero
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			if (!in_z[ZR_W-1]) begin
				x_q <= in_x - ys;
				y_q <= in_y + xs;
				z_q <= in_z - step;
			end else begin
				x_q <= in_x + ys;
				y_q <= in_y - xs;
				z_q <= in_z + step;
			end
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_x = x_q;
	assign out_y = y_q;
	assign out_z = z_q;
	assign out_side = side_q;
endmodule
